FILE: src/tga_rle_pkg.sv
// tga_rle_pkg: shared types and constants for the targa rle pixel decoder
// no dependencies; used by every module under src
`default_nettype none

package tga_rle_pkg;

    localparam int unsigned PIX_W   = 32;
    localparam int unsigned CNT8_W  = 8;
    localparam int unsigned TOTAL_W = 25;
    localparam int unsigned ADDR_W  = 4;

    // register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_PIXEL_BYTES   = 2'd0,
        REG_TOTAL_PIXELS  = 2'd1,
        REG_SWAP_RED_BLUE = 2'd2,
        REG_UNUSED        = 2'd3
    } reg_idx_t;

    localparam logic [2:0] PIXEL_BYTES_MIN   = 3'd1;
    localparam logic [2:0] PIXEL_BYTES_MAX   = 3'd4;
    localparam logic [2:0] PIXEL_BYTES_RESET = 3'd3;
    localparam logic [2:0] SWAP_MIN_BYTES    = 3'd3;

    localparam logic [TOTAL_W-1:0] TOTAL_PIXELS_RESET = TOTAL_W'(1);

    typedef struct packed {
        logic [2:0]         pixel_bytes;
        logic [TOTAL_W-1:0] total_pixels;
        logic               swap_red_blue;
    } cfg_t;

    typedef struct packed {
        logic               clipped;
        logic               last_of_image;
        logic [CNT8_W-1:0]  repeat_count;
        logic [PIX_W-1:0]   pixel_value;
    } res_t;

    function automatic logic [PIX_W-1:0] swap_rb(input logic [PIX_W-1:0] px);
        swap_rb = {px[31:24], px[7:0], px[15:8], px[23:16]};
    endfunction

endpackage

`default_nettype wire

FILE: src/tga_rle_cfg.sv
// tga_rle_cfg: apb register file holding pixel size, image size and swap
// depends on tga_rle_pkg
`default_nettype none

module tga_rle_cfg (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tga_rle_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    output tga_rle_pkg::cfg_t                  cfg
);
    import tga_rle_pkg::*;

    logic [2:0]         pixel_bytes_reg;
    logic [TOTAL_W-1:0] total_pixels_reg;
    logic               swap_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_bytes_reg  <= PIXEL_BYTES_RESET;
            total_pixels_reg <= TOTAL_PIXELS_RESET;
            swap_reg         <= 1'b1;
        end else if (wr_en) begin
            case (idx)
                REG_PIXEL_BYTES:   pixel_bytes_reg  <= pwdata[2:0];
                REG_TOTAL_PIXELS:  total_pixels_reg <= pwdata[TOTAL_W-1:0];
                REG_SWAP_RED_BLUE: swap_reg         <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            REG_PIXEL_BYTES:   prdata = {29'd0, pixel_bytes_reg};
            REG_TOTAL_PIXELS:  prdata = {7'd0, total_pixels_reg};
            REG_SWAP_RED_BLUE: prdata = {31'd0, swap_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign cfg.pixel_bytes   = pixel_bytes_reg;
    assign cfg.total_pixels  = total_pixels_reg;
    assign cfg.swap_red_blue = swap_reg;

endmodule

`default_nettype wire

FILE: src/tga_rle_dec.sv
// tga_rle_dec: packet and pixel state with the single-pass step logic
// depends on tga_rle_pkg; fed from the input register of the top level
`default_nettype none

module tga_rle_dec #(
    parameter int unsigned MAX_PIXELS = 16777216
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              step,
    input  wire logic [7:0]        data_byte,
    input  wire logic              start_of_image,
    input  wire tga_rle_pkg::cfg_t cfg,
    output logic                   res_valid,
    output tga_rle_pkg::res_t      res
);
    import tga_rle_pkg::*;

    localparam int unsigned CNT_W = $clog2(MAX_PIXELS + 1);
    localparam int unsigned CW    = (CNT_W > CNT8_W) ? CNT_W : CNT8_W;

    logic              expect_reg,  expect_next;
    logic              run_reg,     run_next;
    logic [7:0]        pkt_reg,     pkt_next;
    logic [1:0]        pos_reg,     pos_next;
    logic [PIX_W-1:0]  asm_reg,     asm_next;
    logic [CNT_W-1:0]  img_reg,     img_next;

    logic [CNT_W-1:0]  eff_total;
    logic [2:0]        eff_pb;
    logic [CNT_W-1:0]  img_cur;
    logic              expect_cur;
    logic [PIX_W-1:0]  asm_or;
    logic [7:0]        count;
    logic [CW-1:0]     count_w;
    logic [CW-1:0]     img_w;
    logic [CW-1:0]     img_diff;
    logic [7:0]        pkt_dec;
    logic              over;

    always_comb begin
        if (cfg.total_pixels == '0) begin
            eff_total = CNT_W'(1);
        end else if (32'(cfg.total_pixels) > 32'(MAX_PIXELS)) begin
            eff_total = CNT_W'(MAX_PIXELS);
        end else begin
            eff_total = CNT_W'(cfg.total_pixels);
        end
        if (cfg.pixel_bytes == 3'd0) begin
            eff_pb = PIXEL_BYTES_MIN;
        end else if (cfg.pixel_bytes > PIXEL_BYTES_MAX) begin
            eff_pb = PIXEL_BYTES_MAX;
        end else begin
            eff_pb = cfg.pixel_bytes;
        end
    end

    always_comb begin
        img_cur    = start_of_image ? eff_total : img_reg;
        expect_cur = start_of_image | expect_reg;
        asm_or     = asm_reg | (PIX_W'(data_byte) << {pos_reg, 3'b000});
        count      = run_reg ? pkt_reg : 8'd1;
        pkt_dec    = run_reg ? 8'd0 : (pkt_reg - 8'd1);
        count_w    = CW'(count);
        img_w      = CW'(img_cur);
        over       = count_w > img_w;
        if (over) begin
            count = 8'(img_cur);
        end
        img_diff   = img_w - CW'(count);

        expect_next = expect_reg;
        run_next    = run_reg;
        pkt_next    = pkt_reg;
        pos_next    = pos_reg;
        asm_next    = asm_reg;
        img_next    = img_cur;
        res_valid   = 1'b0;

        res.pixel_value   = (cfg.swap_red_blue && eff_pb >= SWAP_MIN_BYTES) ?
                            swap_rb(asm_or) : asm_or;
        res.repeat_count  = count;
        res.last_of_image = (img_diff == '0);
        res.clipped       = over & run_reg;

        if (img_cur == '0) begin
            // image complete: byte dropped
            img_next = img_reg;
        end else if (expect_cur) begin
            run_next    = data_byte[7];
            pkt_next    = {1'b0, data_byte[6:0]} + 8'd1;
            pos_next    = 2'd0;
            asm_next    = '0;
            expect_next = 1'b0;
        end else if (({1'b0, pos_reg} + 3'd1) < eff_pb) begin
            pos_next = pos_reg + 2'd1;
            asm_next = asm_or;
        end else begin
            res_valid   = 1'b1;
            pos_next    = 2'd0;
            asm_next    = '0;
            pkt_next    = pkt_dec;
            img_next    = img_diff[CNT_W-1:0];
            expect_next = (pkt_dec == 8'd0) || (img_diff == '0);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            expect_reg <= 1'b1;
            run_reg    <= 1'b0;
            pkt_reg    <= 8'd0;
            pos_reg    <= 2'd0;
            img_reg    <= '0;
        end else if (step) begin
            expect_reg <= expect_next;
            run_reg    <= run_next;
            pkt_reg    <= pkt_next;
            pos_reg    <= pos_next;
            img_reg    <= img_next;
        end
    end

    // cleared on every header before use
    always_ff @(posedge aclk) begin
        if (step) begin
            asm_reg <= asm_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/tga_rle_pixel_decoder_unit.sv
// a byte taken from s_tdata is held in the input register and decoded there by the
// step logic; its pixel is registered into the output register that drives m_tvalid
// throughput: one byte per cycle, set by the single-pass step logic; an
// output stall holds back the input only when a byte would complete a pixel
// reset: aresetn synchronous active low; registers return to pixel_bytes 3,
// total_pixels 1, swap on, and the image counts as complete until a restart byte
`default_nettype none

module tga_rle_pixel_decoder_unit #(
    parameter int unsigned MAX_PIXELS = 16777216
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready,
    // compressed bytes
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
    input  wire logic        s_tuser,   // [0] start_of_image
    // decoded pixels
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,   // [31:0] pixel_value, [39:32] repeat_count
    output logic             m_tlast,   // last_of_image
    output logic             m_tuser    // [0] clipped
);
    import tga_rle_pkg::*;

    cfg_t       cfg;
    res_t       res;
    logic       res_valid;
    logic       advance;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_sol_reg;
    logic       out_valid_reg;
    res_t       out_res_reg;

    tga_rle_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    tga_rle_dec #(
        .MAX_PIXELS (MAX_PIXELS)
    ) u_dec (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step           (advance),
        .data_byte      (in_byte_reg),
        .start_of_image (in_sol_reg),
        .cfg            (cfg),
        .res_valid      (res_valid),
        .res            (res)
    );

    // a byte moves on unless it completes a pixel while the output is full
    assign advance  = in_valid_reg & (~res_valid | ~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_byte_reg <= s_tdata;
            in_sol_reg  <= s_tuser;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && res_valid) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && res_valid) begin
            out_res_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_res_reg.repeat_count, out_res_reg.pixel_value};
    assign m_tlast  = out_res_reg.last_of_image;
    assign m_tuser  = out_res_reg.clipped;

`ifndef ASSERT_OFF
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && res_valid) |-> (!out_valid_reg || m_tready))
        else $error("pixel result would overwrite a pending item");

    a_count_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:32] != 8'd0))
        else $error("repeat count of zero");

    a_clip_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> m_tlast)
        else $error("clipped run not flagged as last of image");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("stalled byte lost from input register");
`endif

endmodule

`default_nettype wire

FILE: verif/tga_rle_pixel_decoder_unit_tb.sv
// testbench for tga_rle_pixel_decoder_unit: streams packet bytes, predicts every
// decoded pixel in a behavioral decoder and compares results in order
// depends on src/tga_rle_pkg.sv and src/tga_rle_pixel_decoder_unit.sv
`default_nettype none

module tga_rle_pixel_decoder_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tga_rle_pkg::*;

    localparam int unsigned MAX_PIX       = 16777216;
    localparam int unsigned RANDOM_ITEMS  = 700;
    localparam int unsigned HOLD_CYCLES   = 300;
    localparam int unsigned SETTLE_CYCLES = 4;
    localparam int unsigned TIMEOUT_NS    = 2_000_000;

    logic        aclk;
    logic        aresetn;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] data_byte
    logic        s_tuser;   // [0] start_of_image
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // [31:0] pixel_value, [39:32] repeat_count
    logic        m_tlast;   // last_of_image
    logic        m_tuser;   // [0] clipped

    // register shadows
    logic [2:0]         cf_pix_bytes = PIXEL_BYTES_RESET;
    logic [TOTAL_W-1:0] cf_total     = TOTAL_PIXELS_RESET;
    logic               cf_swap      = 1'b1;

    // decoder state
    bit                 st_hdr      = 1'b1;
    bit                 st_run      = 1'b0;
    logic [7:0]         st_pkt_left = '0;
    logic [1:0]         st_bpos     = '0;
    logic [31:0]        st_asm      = '0;
    logic [TOTAL_W-1:0] st_img_left = '0;

    res_t        expected_pixels[$];
    res_t        want_px;
    int unsigned err_count    = 0;
    int unsigned bytes_sent   = 0;
    bit          tx_quiet     = 1'b0;
    bit          rx_quiet     = 1'b0;
    bit          hold_pending = 1'b0;
    int          rx_r;
    int          rx_n;

    tga_rle_pixel_decoder_unit #(
        .MAX_PIXELS(MAX_PIX)
    ) u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    function automatic int unsigned eff_pixel_size();
        if (cf_pix_bytes == 3'd0) return 1;
        if (cf_pix_bytes > PIXEL_BYTES_MAX) return 4;
        return cf_pix_bytes;
    endfunction

    function automatic int unsigned eff_image_size();
        if (cf_total == '0) return 1;
        if (cf_total > MAX_PIX) return MAX_PIX;
        return cf_total;
    endfunction

    // advances the decoder by one byte; returns 1 when a pixel comes out
    function automatic bit decode_byte(input logic [7:0] b, input logic sof,
                                       output res_t px_out);
        int unsigned pb;
        int unsigned cnt;
        logic [31:0] px;
        bit          clip;
        px_out = '0;
        clip   = 1'b0;
        if (sof) begin
            st_img_left = TOTAL_W'(eff_image_size());
            st_hdr      = 1'b1;
        end
        if (st_img_left == '0) return 1'b0;
        if (st_hdr) begin
            st_run      = b[7];
            st_pkt_left = {1'b0, b[6:0]} + 8'd1;
            st_bpos     = '0;
            st_asm      = '0;
            st_hdr      = 1'b0;
            return 1'b0;
        end
        st_asm = st_asm | (32'(b) << (8 * st_bpos));
        pb = eff_pixel_size();
        if (int'(st_bpos) + 1 < pb) begin
            st_bpos = st_bpos + 2'd1;
            return 1'b0;
        end
        px = st_asm;
        if (cf_swap && pb >= SWAP_MIN_BYTES) begin
            px[7:0]   = st_asm[23:16];
            px[23:16] = st_asm[7:0];
        end
        st_bpos = '0;
        st_asm  = '0;
        if (st_run) begin
            cnt         = st_pkt_left;
            st_pkt_left = '0;
        end else begin
            cnt         = 1;
            st_pkt_left = st_pkt_left - 8'd1;
        end
        if (cnt > st_img_left) begin
            cnt  = st_img_left;
            clip = st_run;
        end
        st_img_left = st_img_left - TOTAL_W'(cnt);
        if (st_pkt_left == '0 || st_img_left == '0) st_hdr = 1'b1;
        px_out.pixel_value   = px;
        px_out.repeat_count  = cnt[7:0];
        px_out.last_of_image = (st_img_left == '0);
        px_out.clipped       = clip;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        err_count++;
        $display("mismatch at %0t: %s", $time, what);
    endtask

    // called at a rising edge; returns at a rising edge after the item is taken
    task automatic send_byte(input logic [7:0] b, input logic sof);
        res_t px;
        int   r;
        int   n;
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= sof;
        @(negedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
            @(negedge aclk);
        end
        if (decode_byte(b, sof, px)) expected_pixels.push_back(px);
        bytes_sent++;
        @(posedge aclk);
        r = $urandom_range(0, 99);
        if (tx_quiet || r < 65) n = 0;
        else if (r < 95)        n = $urandom_range(1, 3);
        else                    n = $urandom_range(10, 30);
        if (n > 0) begin
            s_tvalid <= 1'b0;
            repeat (n) @(posedge aclk);
        end
    endtask

    task automatic send_pixel(input int unsigned pb);
        repeat (pb) send_byte(8'($urandom), 1'b0);
    endtask

    // no pixel outstanding, and bytes still in the pipe have settled
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    // upper bits of each write are junk that the block must ignore
    task automatic set_config(input logic [2:0] pb, input logic [TOTAL_W-1:0] tot,
                              input logic sw);
        wait_idle();
        apb_write(REG_PIXEL_BYTES, ($urandom() & ~32'h7) | 32'(pb));
        apb_write(REG_TOTAL_PIXELS, ($urandom() & ~32'h1FF_FFFF) | 32'(tot));
        apb_write(REG_SWAP_RED_BLUE, ($urandom() & ~32'h1) | 32'(sw));
        cf_pix_bytes = pb;
        cf_total     = tot;
        cf_swap      = sw;
    endtask

    task automatic test_reset_state();
        send_byte(8'hA5, 1'b0);     // image counts as complete: dropped
        send_byte(8'h00, 1'b1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h33, 1'b0);
        send_byte(8'h44, 1'b0);
    endtask

    task automatic test_packet_kinds();
        set_config(3'd1, 25'd10, 1'b1);
        send_byte(8'h82, 1'b1);     // run of 3
        send_byte(8'h00, 1'b0);
        send_byte(8'h01, 1'b0);     // two literals
        send_byte(8'hFF, 1'b0);
        send_byte(8'h7E, 1'b0);
        send_byte(8'hFF, 1'b0);     // run of 128, cut to the 5 left
        send_byte(8'h80, 1'b0);
        send_byte(8'h55, 1'b0);
    endtask

    task automatic test_size_extremes();
        set_config(3'd7, 25'd0, 1'b0);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        set_config(3'd0, 25'h1FF_FFFF, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'hC3, 1'b0);
    endtask

    // size shrinks mid-pixel; image size change must not touch the running image
    task automatic test_partial_pixel();
        set_config(3'd4, 25'd2, 1'b1);
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        set_config(3'd1, 25'd1, 1'b1);
        send_byte(8'h03, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h9C, 1'b0);
    endtask

    task automatic test_backpressure();
        set_config(3'd1, 25'd64, 1'b0);
        hold_pending = 1'b1;
        send_byte(8'h3F, 1'b1);
        repeat (64) send_byte(8'($urandom), 1'b0);
        wait_idle();
    endtask

    task automatic test_random_images();
        int unsigned first;
        int unsigned left;
        int unsigned pb;
        int unsigned n;
        int unsigned i;
        int          r;
        int          npk;
        bit          run;
        bit          overrun;
        logic [2:0]  new_pb;
        logic [TOTAL_W-1:0] new_tot;
        first = bytes_sent;
        while (bytes_sent - first < RANDOM_ITEMS) begin
            if ($urandom_range(0, 3) == 0) begin
                r = $urandom_range(0, 99);
                new_pb = (r < 80) ? 3'($urandom_range(1, 4)) : 3'($urandom_range(0, 7));
                r = $urandom_range(0, 99);
                if (r < 85)      new_tot = TOTAL_W'($urandom_range(1, 40));
                else if (r < 95) new_tot = TOTAL_W'($urandom_range(41, 300));
                else if (r < 98) new_tot = TOTAL_W'($urandom_range(MAX_PIX - 8, MAX_PIX + 8));
                else             new_tot = TOTAL_W'($urandom_range(0, 1) ? 0 : 25'h1FF_FFFF);
                set_config(new_pb, new_tot, 1'($urandom_range(0, 1)));
            end
            tx_quiet = ($urandom_range(0, 5) == 0);
            rx_quiet = ($urandom_range(0, 5) == 0);
            pb = eff_pixel_size();
            r  = $urandom_range(0, 99);
            if (r < 85) begin
                // well-formed image, capped at a dozen packets for huge sizes
                left    = eff_image_size();
                npk     = 0;
                overrun = ($urandom_range(0, 4) == 0);
                while (left > 0 && npk < 12) begin
                    run = 1'($urandom_range(0, 1));
                    r   = $urandom_range(0, 99);
                    if (r < 5 && (run || pb == 1)) n = 128;
                    else if (r < 15 && (run || pb == 1)) n = $urandom_range(1, 128);
                    else if (r < 15) n = $urandom_range(1, 16);
                    else n = $urandom_range(1, 8);
                    send_byte({run, 7'(n - 1)}, npk == 0);
                    npk++;
                    if (run) begin
                        send_pixel(pb);
                        left = (n >= left) ? 0 : left - n;
                    end else begin
                        for (i = 0; i < n && (left > 0 || overrun); i++) begin
                            send_pixel(pb);
                            if (left > 0) left--;
                        end
                    end
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 3)) send_byte(8'($urandom), 1'b0);
            end else if (r < 93) begin
                repeat ($urandom_range(1, 12))
                    send_byte(8'($urandom), $urandom_range(0, 9) == 0);
            end else begin
                // restart, then a pixel that may be left unfinished
                send_byte(8'($urandom), 1'b1);
                repeat ($urandom_range(0, pb)) send_byte(8'($urandom), 1'b0);
            end
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        m_tready = 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_pending) begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                m_tready <= 1'b1;
            end else begin
                rx_r = $urandom_range(0, 99);
                if (rx_quiet || rx_r < 70) begin
                    m_tready <= 1'b1;
                end else begin
                    m_tready <= 1'b0;
                    rx_n = (rx_r < 95) ? $urandom_range(0, 2) : $urandom_range(10, 40);
                    repeat (rx_n) @(posedge aclk);
                end
            end
        end
    end

    // outputs are stable at the falling edge; a handshake seen here completes
    // at the next rising edge
    always @(negedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_pixels.size() == 0) begin
                report_mismatch($sformatf("pixel %h with none expected", m_tdata));
            end else begin
                want_px = expected_pixels.pop_front();
                if (m_tdata[31:0] !== want_px.pixel_value)
                    report_mismatch($sformatf("pixel_value %h, want %h",
                                              m_tdata[31:0], want_px.pixel_value));
                if (m_tdata[39:32] !== want_px.repeat_count)
                    report_mismatch($sformatf("repeat_count %0d, want %0d",
                                              m_tdata[39:32], want_px.repeat_count));
                if (m_tlast !== want_px.last_of_image)
                    report_mismatch($sformatf("last_of_image %b, want %b",
                                              m_tlast, want_px.last_of_image));
                if (m_tuser !== want_px.clipped)
                    report_mismatch($sformatf("clipped %b, want %b",
                                              m_tuser, want_px.clipped));
            end
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        aresetn  = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = 1'b0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_reset_state();
        test_packet_kinds();
        test_size_extremes();
        test_partial_pixel();
        test_backpressure();
        test_random_images();

        wait_idle();
        repeat (10) @(posedge aclk);
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

`default_nettype wire
